@@ rtl/mstt_pkg.sv @@
// ----------------------------------------------------------------------------
// mstt_pkg: shared types and constants for the timer slot table
// Operation and result codes, the slot word stored in RAM, default sizes.
// ----------------------------------------------------------------------------
package mstt_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int MAX_OUT   = 16;
  localparam int FCW       = $clog2(MAX_OUT + 1);

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DEL    = 2'd1;
  localparam logic [1:0] OP_DELALL = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_DEL  = 2'd1;
  localparam logic [1:0] KIND_FIRE = 2'd2;

  typedef struct packed {
    logic [15:0] owner;
    logic [31:0] argument;
    logic [31:0] interval;
    logic        periodic;
    logic [31:0] start;
  } slot_t;

endpackage

@@ rtl/mstt_ram.sv @@
// ----------------------------------------------------------------------------
// mstt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when re is low.
// ----------------------------------------------------------------------------
module mstt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/multi_slot_timer_table.sv @@
// ----------------------------------------------------------------------------
// multi_slot_timer_table: table of one-shot and periodic timer slots
//
// Input channel (in_valid/in_ready) takes one command beat: add, delete by
// owner, delete all, or tick with the current time. in_ready is high only
// while the block is idle; one command is worked on at a time.
// Output channel (out_valid/out_ready) gives result beats: one add status or
// delete-done beat per add/delete, and one fired beat per due slot on a tick
// (none if nothing is due, at most 16). last marks the final beat of a command.
// Slot words live in one RAM with a registered read; active bits are
// flip-flops. Add, delete and tick sweep the RAM one slot per cycle, a tick
// only while no held fired beat is stalled; delete-all skips the sweep.
// A fired beat is held back until the next due slot or the end of the sweep,
// so that last can be set; when the receiver stalls the sweep waits on the
// next due slot.
// Reset frees every slot at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_slot_timer_table #(
  parameter int SLOTS = mstt_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [15:0] timer_owner,
  input  logic [31:0] argument,
  input  logic [31:0] interval_ms,
  input  logic        periodic,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic        status,
  output logic [3:0]  fired_slot,
  output logic [15:0] fired_owner,
  output logic [31:0] fired_argument,
  output logic        last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
  localparam int FCW = mstt_pkg::FCW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state;

  logic [1:0]  op_q;
  logic [15:0] owner_q;
  logic [31:0] arg_q;
  logic [31:0] ivl_q;
  logic        per_q;
  logic [31:0] now_q;

  logic [SLOTS-1:0] active;
  logic [CW-1:0]    ridx;
  logic             e_valid;
  logic [IW-1:0]    eidx;
  logic             free_found;
  logic [IW-1:0]    free_idx;
  logic [FCW-1:0]   fcount;

  logic        pend_valid;
  logic [3:0]  pend_slot;
  logic [15:0] pend_owner;
  logic [31:0] pend_arg;

  mstt_pkg::slot_t rd_word;
  mstt_pkg::slot_t wr_word;
  logic [$bits(mstt_pkg::slot_t)-1:0] rd_bits;
  logic          rd_en;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] rd_addr;

  logic        out_free;
  logic        cur_act;
  logic        match;
  logic [31:0] elapsed;
  logic        due;
  logic        ev_fire;
  logic        ev_done;
  logic        ev_take;
  logic        fire_take;
  logic        go;
  logic        stop;
  logic        scan_end;
  logic        add_wr;
  logic [IW+3:0] eidx_ext;

  assign in_ready = (state == ST_IDLE);
  assign rd_word  = mstt_pkg::slot_t'(rd_bits);
  assign out_free = !out_valid || out_ready;
  assign cur_act  = active[eidx];
  assign match    = (rd_word.owner == owner_q);
  assign elapsed  = now_q - rd_word.start;
  assign due      = cur_act && (elapsed >= rd_word.interval);
  assign eidx_ext = {4'b0000, eidx};

  assign ev_fire   = (state == ST_SCAN) && e_valid && (op_q == mstt_pkg::OP_TICK) && due;
  assign ev_done   = !ev_fire || !pend_valid || out_free;
  assign ev_take   = (state == ST_SCAN) && e_valid && ev_done;
  assign fire_take = ev_fire && ev_done;
  assign go        = (state == ST_SCAN) && (!e_valid || ev_done);
  assign stop      = fire_take && (fcount == FCW'(mstt_pkg::MAX_OUT - 1));
  assign scan_end  = (state == ST_SCAN) && ((!e_valid && (ridx == SLOTS_C)) || stop);
  assign rd_en     = go && (ridx != SLOTS_C);
  assign rd_addr   = ridx[IW-1:0];

  assign add_wr = (state == ST_FIN) && (op_q == mstt_pkg::OP_ADD) && free_found && out_free;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = eidx;
    wr_word = rd_word;
    if (fire_take && rd_word.periodic) begin
      wr_en         = 1'b1;
      wr_word.start = now_q;
    end else if (add_wr) begin
      wr_en            = 1'b1;
      wr_addr          = free_idx;
      wr_word.owner    = owner_q;
      wr_word.argument = arg_q;
      wr_word.interval = ivl_q;
      wr_word.periodic = per_q;
      wr_word.start    = now_q;
    end
  end

  mstt_ram #(
    .WIDTH($bits(mstt_pkg::slot_t)),
    .DEPTH(SLOTS),
    .AW   (IW)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_word),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_bits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      active     <= '0;
      pend_valid <= 1'b0;
      e_valid    <= 1'b0;
      fcount     <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_q       <= op;
            owner_q    <= timer_owner;
            arg_q      <= argument;
            ivl_q      <= interval_ms;
            per_q      <= periodic;
            now_q      <= now_ms;
            ridx       <= '0;
            e_valid    <= 1'b0;
            fcount     <= '0;
            free_found <= 1'b0;
            pend_valid <= 1'b0;
            if (op == mstt_pkg::OP_DELALL) begin
              active <= '0;
              state  <= ST_FIN;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (go) begin
            e_valid <= rd_en;
            eidx    <= ridx[IW-1:0];
            if (rd_en) begin
              ridx <= ridx + 1'b1;
            end
          end
          if (ev_take) begin
            unique case (op_q)
              mstt_pkg::OP_ADD: begin
                if (match) begin
                  active[eidx] <= 1'b0;
                end
                if (!(cur_act && !match) && !free_found) begin
                  free_found <= 1'b1;
                  free_idx   <= eidx;
                end
              end
              mstt_pkg::OP_DEL: begin
                if (match) begin
                  active[eidx] <= 1'b0;
                end
              end
              mstt_pkg::OP_DELALL: begin
                active <= '0;
              end
              mstt_pkg::OP_TICK: begin
                if (fire_take) begin
                  if (!rd_word.periodic) begin
                    active[eidx] <= 1'b0;
                  end
                  if (pend_valid) begin
                    out_valid      <= 1'b1;
                    kind           <= mstt_pkg::KIND_FIRE;
                    status         <= 1'b0;
                    fired_slot     <= pend_slot;
                    fired_owner    <= pend_owner;
                    fired_argument <= pend_arg;
                    last           <= 1'b0;
                  end
                  pend_valid <= 1'b1;
                  pend_slot  <= eidx_ext[3:0];
                  pend_owner <= rd_word.owner;
                  pend_arg   <= rd_word.argument;
                  fcount     <= fcount + 1'b1;
                end
              end
            endcase
          end
          if (scan_end) begin
            e_valid <= 1'b0;
            state   <= ST_FIN;
          end
        end
        ST_FIN: begin
          unique case (op_q)
            mstt_pkg::OP_ADD: begin
              if (out_free) begin
                if (free_found) begin
                  active[free_idx] <= 1'b1;
                end
                out_valid      <= 1'b1;
                kind           <= mstt_pkg::KIND_ADD;
                status         <= !free_found;
                fired_slot     <= '0;
                fired_owner    <= '0;
                fired_argument <= '0;
                last           <= 1'b1;
                state          <= ST_IDLE;
              end
            end
            mstt_pkg::OP_DEL, mstt_pkg::OP_DELALL: begin
              if (out_free) begin
                out_valid      <= 1'b1;
                kind           <= mstt_pkg::KIND_DEL;
                status         <= 1'b0;
                fired_slot     <= '0;
                fired_owner    <= '0;
                fired_argument <= '0;
                last           <= 1'b1;
                state          <= ST_IDLE;
              end
            end
            mstt_pkg::OP_TICK: begin
              if (!pend_valid) begin
                state <= ST_IDLE;
              end else if (out_free) begin
                out_valid      <= 1'b1;
                kind           <= mstt_pkg::KIND_FIRE;
                status         <= 1'b0;
                fired_slot     <= pend_slot;
                fired_owner    <= pend_owner;
                fired_argument <= pend_arg;
                last           <= 1'b1;
                pend_valid     <= 1'b0;
                state          <= ST_IDLE;
              end
            end
          endcase
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_rw_same_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("slot write collides with sweep read");

  a_fire_count_bound: assert property (@(posedge clk) disable iff (rst)
    fcount <= FCW'(mstt_pkg::MAX_OUT))
    else $error("fired beat count above limit");

  a_pend_tick_only: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (op_q == mstt_pkg::OP_TICK))
    else $error("held fired beat outside a tick");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("fired beat left behind at end of tick");

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for the timer slot table
// A predictor keeps its own copy of the slot table and works out the beats
// each accepted command owes. A checker compares every result beat with the
// oldest owed beat. Directed commands fill, overflow and flush the table,
// then random add/tick/delete traffic runs under three idle patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N           = mstt_pkg::SLOTS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 2 * N + 8;
  localparam int MAX_SHOWN   = 40;

  localparam logic ST_STORED = 1'b0;
  localparam logic ST_FULL   = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic        status;
    logic [3:0]  slot;
    logic [15:0] owner;
    logic [31:0] arg;
    logic        last;
  } beat_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = mstt_pkg::OP_TICK;
  logic [15:0] timer_owner = '0;
  logic [31:0] argument = '0;
  logic [31:0] interval_ms = '0;
  logic        periodic = 1'b0;
  logic [31:0] now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic        status;
  logic [3:0]  fired_slot;
  logic [15:0] fired_owner;
  logic [31:0] fired_argument;
  logic        last;

  multi_slot_timer_table DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .timer_owner(timer_owner), .argument(argument),
    .interval_ms(interval_ms), .periodic(periodic), .now_ms(now_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .status(status), .fired_slot(fired_slot),
    .fired_owner(fired_owner), .fired_argument(fired_argument), .last(last)
  );

  // shadow slot table
  logic        tt_active[N];
  logic [15:0] tt_owner[N];
  logic [31:0] tt_arg[N];
  logic [31:0] tt_ivl[N];
  logic        tt_per[N];
  logic [31:0] tt_start[N];

  beat_t owed_beats[$];

  int errors = 0;
  int cmds_sent = 0;
  int beats_seen = 0;
  int fires_seen = 0;
  int full_seen = 0;
  int idle_cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  logic [31:0] wall_ms;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < N; i++) begin
      tt_active[i] = 1'b0;
      tt_owner[i]  = '0;
    end
  end

  task automatic flag_mismatch(input string what);
    if (errors < MAX_SHOWN) $display("ERROR @%0t: %s", $time, what);
    errors++;
  endtask

  function automatic void apply_command(input logic [1:0] c_op, input logic [15:0] who,
                                        input logic [31:0] arg, input logic [31:0] ivl,
                                        input logic per, input logic [31:0] now);
    beat_t b;
    logic placed;
    logic [31:0] age;
    int fire_last;
    int n;
    b = '0;
    b.last = 1'b1;
    case (c_op)
      mstt_pkg::OP_ADD: begin
        placed = 1'b0;
        for (int i = 0; i < N; i++)
          if (tt_owner[i] == who) tt_active[i] = 1'b0;
        for (int i = 0; i < N; i++) begin
          if (!placed && !tt_active[i]) begin
            tt_active[i] = 1'b1;
            tt_owner[i]  = who;
            tt_arg[i]    = arg;
            tt_ivl[i]    = ivl;
            tt_per[i]    = per;
            tt_start[i]  = now;
            placed       = 1'b1;
          end
        end
        b.kind   = mstt_pkg::KIND_ADD;
        b.status = placed ? ST_STORED : ST_FULL;
        owed_beats.push_back(b);
      end
      mstt_pkg::OP_DEL: begin
        for (int i = 0; i < N; i++)
          if (tt_owner[i] == who) tt_active[i] = 1'b0;
        b.kind = mstt_pkg::KIND_DEL;
        owed_beats.push_back(b);
      end
      mstt_pkg::OP_DELALL: begin
        for (int i = 0; i < N; i++) tt_active[i] = 1'b0;
        b.kind = mstt_pkg::KIND_DEL;
        owed_beats.push_back(b);
      end
      default: begin
        // first pass finds the final due slot so last can be marked
        fire_last = -1;
        n = 0;
        for (int i = 0; i < N; i++) begin
          age = now - tt_start[i];
          if (n < mstt_pkg::MAX_OUT && tt_active[i] && age >= tt_ivl[i]) begin
            fire_last = i;
            n++;
          end
        end
        n = 0;
        for (int i = 0; i < N; i++) begin
          age = now - tt_start[i];
          if (n < mstt_pkg::MAX_OUT && tt_active[i] && age >= tt_ivl[i]) begin
            b.kind  = mstt_pkg::KIND_FIRE;
            b.slot  = i[3:0];
            b.owner = tt_owner[i];
            b.arg   = tt_arg[i];
            b.last  = (i == fire_last);
            owed_beats.push_back(b);
            if (tt_per[i]) tt_start[i] = now;
            else tt_active[i] = 1'b0;
            n++;
          end
        end
      end
    endcase
  endfunction

  task automatic send_cmd(input logic [1:0] c_op, input logic [15:0] who,
                          input logic [31:0] arg, input logic [31:0] ivl,
                          input logic per, input logic [31:0] now);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid    <= 1'b1;
    op          <= c_op;
    timer_owner <= who;
    argument    <= arg;
    interval_ms <= ivl;
    periodic    <= per;
    now_ms      <= now;
    do @(posedge clk); while (!in_ready);
    apply_command(c_op, who, arg, ivl, per, now);
    cmds_sent++;
  endtask

  // hold off the sender until every owed beat is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_beats.size() != 0);
  endtask

  task automatic test_idle_table();
    send_cmd(mstt_pkg::OP_TICK, 16'($urandom), $urandom, $urandom, 1'b1, 32'd0);
    send_cmd(mstt_pkg::OP_DEL, 16'h0000, $urandom, $urandom, 1'b0, $urandom);
    send_cmd(mstt_pkg::OP_DELALL, 16'($urandom), $urandom, $urandom, 1'b1, $urandom);
  endtask

  task automatic test_full_table();
    logic [15:0] who;
    logic [31:0] arg;
    for (int i = 0; i < N; i++) begin
      who = (i == N - 1) ? 16'hFFFF : 16'(i + 1);
      arg = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
      send_cmd(mstt_pkg::OP_ADD, who, arg, 32'(i), i[0], 32'hFFFF_FFF8);
    end
    send_cmd(mstt_pkg::OP_ADD, 16'h8000, $urandom, 32'd5, 1'b0, 32'hFFFF_FFF8);
    // existing owner frees its own slot and lands back in it
    send_cmd(mstt_pkg::OP_ADD, 16'd3, $urandom, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFF8);
    drain_results();
    // age wraps to all ones: every slot is due
    send_cmd(mstt_pkg::OP_TICK, 16'($urandom), $urandom, $urandom, 1'b0, 32'hFFFF_FFF7);
    send_cmd(mstt_pkg::OP_TICK, 16'($urandom), $urandom, $urandom, 1'b1, 32'hFFFF_FFF7);
    send_cmd(mstt_pkg::OP_DEL, 16'd2, $urandom, $urandom, 1'b1, $urandom);
    send_cmd(mstt_pkg::OP_DELALL, 16'($urandom), $urandom, $urandom, 1'b0, $urandom);
  endtask

  function automatic logic [15:0] pick_owner();
    case ($urandom_range(9))
      7:       return 16'hFFFF;
      8, 9:    return 16'($urandom);
      default: return 16'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [31:0] pick_interval();
    case ($urandom_range(9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(1, 80);
    endcase
  endfunction

  task automatic test_random_traffic(input int n_items);
    int pick;
    logic [31:0] when;
    drain_results();
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(19) == 0) drain_results();
      if ($urandom_range(24) == 0) wall_ms += $urandom;
      else wall_ms += $urandom_range(0, 40);
      when = ($urandom_range(19) == 0) ? $urandom : wall_ms;
      pick = $urandom_range(99);
      if (pick < 45)
        send_cmd(mstt_pkg::OP_ADD, pick_owner(), $urandom, pick_interval(),
                 1'($urandom_range(1)), when);
      else if (pick < 80)
        send_cmd(mstt_pkg::OP_TICK, 16'($urandom), $urandom, $urandom,
                 1'($urandom_range(1)), when);
      else if (pick < 96)
        send_cmd(mstt_pkg::OP_DEL, pick_owner(), $urandom, $urandom,
                 1'($urandom_range(1)), $urandom);
      else
        send_cmd(mstt_pkg::OP_DELALL, 16'($urandom), $urandom, $urandom,
                 1'($urandom_range(1)), $urandom);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin : check_beats
    beat_t want;
    if (!rst && out_valid && out_ready) begin
      beats_seen++;
      if (owed_beats.size() == 0) begin
        flag_mismatch($sformatf("beat kind %0d with nothing owed", kind));
      end else begin
        want = owed_beats.pop_front();
        if (want.kind == mstt_pkg::KIND_FIRE) fires_seen++;
        if (want.kind == mstt_pkg::KIND_ADD && want.status == ST_FULL) full_seen++;
        if (kind !== want.kind)
          flag_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
        if (status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (fired_slot !== want.slot)
          flag_mismatch($sformatf("fired_slot %0d, want %0d", fired_slot, want.slot));
        if (fired_owner !== want.owner)
          flag_mismatch($sformatf("fired_owner %h, want %h", fired_owner, want.owner));
        if (fired_argument !== want.arg)
          flag_mismatch($sformatf("fired_argument %h, want %h", fired_argument, want.arg));
        if (last !== want.last)
          flag_mismatch($sformatf("last %0d, want %0d", last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d owed", STALL_LIMIT, owed_beats.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    wall_ms = $urandom;
    send_idle = 26;
    recv_idle = 55;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_idle_table();
    test_full_table();
    test_random_traffic(42);
    send_idle = 55;
    recv_idle = 26;
    test_random_traffic(42);
    send_idle = 0;
    recv_idle = 0;
    test_random_traffic(42);
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_beats.size() != 0);
    repeat (SETTLE) @(posedge clk);
    $display("run: %0d commands, %0d result beats (%0d fired, %0d table-full), %0d errors",
             cmds_sent, beats_seen, fires_seen, full_seen, errors);
    $display("run: fill/overflow/flush, wrapped ages, add/tick/delete traffic, three idle mixes");
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mstt_pkg.sv
rtl/mstt_ram.sv
rtl/multi_slot_timer_table.sv
sim/tb.sv
